@@ hdl/wbps_pkg.sv @@
// Shared constants, codes and types of the wildcard byte pattern search.
`timescale 1ns / 1ps
package wbps_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int IDX_W       = $clog2(PATTERN_MAX);
    localparam int LEN_W       = 7;
    localparam int BYTE_W      = 8;
    localparam int ADDR_W      = 48;
    localparam int POS_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = ADDR_W;

    localparam int IN_FIELDS_W  = IDX_W + BYTE_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 1 + ADDR_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // request kinds carried on tuser
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_DATA = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH = 2'd0,
        CFG_WILDCARD_BYTE  = 2'd1,
        CFG_BASE_ADDRESS   = 2'd2
    } t_cfg_reg;

    // broadcast to every cell
    typedef struct packed {
        logic              step;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] wild;
    } t_cell_ctl;

endpackage

@@ hdl/wbps_cell.sv @@
// One pattern position: stored pattern byte and its partial-match bit.
`timescale 1ns / 1ps
module wbps_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wbps_pkg::t_cell_ctl i_ctl,
    input  logic               i_load,
    input  logic               i_use,
    input  logic               i_tail,
    input  logic               i_chain,
    output logic               o_bit,
    output logic               o_tap
);
    import wbps_pkg::*;

    logic [BYTE_W-1:0] r_pat;
    logic              r_bit;
    logic              n_bit;
    logic              w_hit;

    assign w_hit = (r_pat == i_ctl.wild) || (r_pat == i_ctl.data);
    assign n_bit = i_use & w_hit & i_chain;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pat <= i_ctl.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else if (i_ctl.step) begin
            r_bit <= n_bit;
        end
    end

    assign o_bit = r_bit;
    assign o_tap = r_bit & i_tail;

endmodule

@@ hdl/wildcard_byte_pattern_search.sv @@
// Top level: cell row, match tracking and result register.
//
//  channel  dir  handshake                       payload
//  s_axis   in   s_axis_tvalid / s_axis_tready    tdata {byte_value, pattern_index}, tuser
//                                                 req_type, tlast last_byte
//  m_axis   out  m_axis_tvalid / m_axis_tready    tdata {match_address, found}
//  cfg      in   i_cfg_valid / o_cfg_ready        i_cfg_index, i_cfg_data
//
// One item per cycle while the input is not stalled: every cell compares the
// broadcast byte and passes its registered partial-match bit to its neighbor.
// After its last data byte a result is registered in the cell row, the match tracker
// and, through the base address adder, the output register. Reset clears match and
// valid state, wildcard and base, sets length 1; pattern bytes hold junk until loaded.
// Input stalls only while a result waits in the tracker and the output is held.
`timescale 1ns / 1ps
module wildcard_byte_pattern_search (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [5:0] pattern_index, [13:6] byte_value, rest zero
    input  logic [wbps_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [0] req_type
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] found, [48:1] match_address, rest zero
    output logic [wbps_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import wbps_pkg::*;

    // configuration registers
    logic [LEN_W-1:0]  r_len;
    logic [BYTE_W-1:0] r_wild;
    logic [ADDR_W-1:0] r_base;

    // region state
    logic [POS_W-1:0]  r_pos;
    logic              r_fresh;
    logic              r_seen;
    logic [POS_W-1:0]  r_off;

    // stage after the cell row
    logic              r_s1_valid;
    logic              r_s1_last;
    logic              r_s1_zero;
    logic [POS_W-1:0]  r_s1_pos;

    // pending result
    logic              r_s2_valid;
    logic              r_s2_found;
    logic [POS_W-1:0]  r_s2_off;

    // output register
    logic              r_out_valid;
    logic              r_out_found;
    logic [ADDR_W-1:0] r_out_addr;

    logic              w_en;
    logic              w_out_free;
    logic              w_acc;
    logic              w_data_acc;
    logic              w_load_acc;
    logic [IDX_W-1:0]  w_idx;
    logic [BYTE_W-1:0] w_byte;
    t_cell_ctl         w_ctl;
    logic [PATTERN_MAX-1:0] w_bit;
    logic [PATTERN_MAX-1:0] w_tap;
    logic [PATTERN_MAX-1:0] w_tail;
    logic [PATTERN_MAX-1:0] w_chain;
    logic [LEN_W-1:0]  w_len_m1;
    logic              w_hit;
    logic              n_seen;
    logic [POS_W-1:0]  n_off;

    assign o_cfg_ready = 1'b1;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_en          = !r_s2_valid || w_out_free;
    assign s_axis_tready = w_en;

    assign w_acc      = s_axis_tvalid && s_axis_tready;
    assign w_data_acc = w_acc && (s_axis_tuser == REQ_DATA);
    assign w_load_acc = w_acc && (s_axis_tuser == REQ_LOAD);
    assign w_idx      = s_axis_tdata[IDX_W-1:0];
    assign w_byte     = s_axis_tdata[IDX_W +: BYTE_W];

    assign w_ctl.step = w_data_acc;
    assign w_ctl.data = w_byte;
    assign w_ctl.wild = r_wild;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= LEN_W'(1);
            r_wild <= '0;
            r_base <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PATTERN_LENGTH: r_len  <= i_cfg_data[LEN_W-1:0];
                CFG_WILDCARD_BYTE:  r_wild <= i_cfg_data[BYTE_W-1:0];
                CFG_BASE_ADDRESS:   r_base <= i_cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // cell row
    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        localparam logic [LEN_W-1:0] KP1 = LEN_W'(k + 1);
        localparam logic [LEN_W-1:0] KV  = LEN_W'(k);
        localparam logic [IDX_W-1:0] KI  = IDX_W'(k);
        logic w_use;

        assign w_use = (r_len > KV);
        if (k == PATTERN_MAX - 1) begin : g_end
            // lengths beyond the row saturate to the last cell
            assign w_tail[k] = (r_len >= KP1);
        end else begin : g_mid
            assign w_tail[k] = (r_len == KP1);
        end
        if (k == 0) begin : g_head
            assign w_chain[k] = 1'b1;
        end else begin : g_link
            // drop carries left over from the previous region
            assign w_chain[k] = w_bit[k-1] & ~r_fresh;
        end

        wbps_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_load  (w_load_acc && (w_idx == KI)),
            .i_use   (w_use),
            .i_tail  (w_tail[k]),
            .i_chain (w_chain[k]),
            .o_bit   (w_bit[k]),
            .o_tap   (w_tap[k])
        );
    end

    // byte position and region start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_fresh    <= 1'b1;
            r_s1_valid <= 1'b0;
            r_s1_last  <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= w_data_acc;
            r_s1_last  <= w_data_acc && s_axis_tlast;
            if (w_data_acc) begin
                r_pos   <= s_axis_tlast ? '0 : r_pos + POS_W'(1);
                r_fresh <= s_axis_tlast;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_data_acc) begin
            r_s1_pos  <= r_pos;
            r_s1_zero <= (r_len == '0);
        end
    end

    // match tracking
    assign w_len_m1 = (r_len > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX - 1)
                                                    : r_len - LEN_W'(1);
    assign w_hit    = r_s1_zero || (|w_tap);
    assign n_seen   = r_seen || w_hit;
    assign n_off    = r_seen    ? r_off :
                      r_s1_zero ? r_s1_pos :
                                  r_s1_pos - POS_W'(w_len_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= 1'b0;
            r_off      <= '0;
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid <= r_s1_valid && r_s1_last;
            if (r_s1_valid) begin
                if (r_s1_last) begin
                    r_seen <= 1'b0;
                    r_off  <= '0;
                end else begin
                    r_seen <= n_seen;
                    r_off  <= n_off;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_s1_valid && r_s1_last) begin
            r_s2_found <= n_seen;
            r_s2_off   <= n_off;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_s2_valid && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid && w_out_free) begin
            r_out_found <= r_s2_found;
            r_out_addr  <= r_s2_found ? r_base + ADDR_W'(r_s2_off) : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, r_out_addr, r_out_found};

    a_stall_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while a result is blocked");

    a_last_clears_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_data_acc && s_axis_tlast) |=> (r_s1_valid && r_s1_last && r_pos == '0))
        else $error("region end did not restart the byte position");

    a_no_match_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_addr == '0))
        else $error("address nonzero without a match");

    a_tail_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len != '0) |-> $onehot(w_tail))
        else $error("pattern tail select is not one-hot");

    a_pending_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !w_en) |=> (r_s2_valid && $stable(r_s2_off)))
        else $error("pending result lost while output stalled");

endmodule

@@ bench/wildcard_byte_pattern_search_test.sv @@
// Self-checking stream testbench for the wildcard byte pattern search block.
`timescale 1ns / 1ps
module wildcard_byte_pattern_search_test;
    import wbps_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_ITEMS   = 1750;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int REGION_MAX     = 256;
    localparam int DIR_ROWS       = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam logic [ADDR_W-1:0]    ADDR_MAX     = '1;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] addr;
    } t_scan_report;

    localparam t_scan_report NO_HIT = '{1'b0, '0};

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic                  req;
        logic [IDX_W-1:0]      idx;
        logic [BYTE_W-1:0]     val;
        logic                  last;
        logic                  pinned;
        t_scan_report          pin;
    } t_dir_row;

    // kind, register, value, req, index, byte, last, pinned, pinned report
    t_dir_row dir_tab [DIR_ROWS] = '{
        '{ROW_ITEM, '0, '0, REQ_LOAD, 6'd0,  8'h41, 1'b0, 1'b0, NO_HIT},
        '{ROW_ITEM, '0, '0, REQ_DATA, 6'd0,  8'h41, 1'b1, 1'b1, '{1'b1, 48'h0}},
        '{ROW_ITEM, '0, '0, REQ_DATA, 6'd0,  8'h00, 1'b1, 1'b1, NO_HIT},
        '{ROW_ITEM, '0, '0, REQ_LOAD, 6'd63, 8'hFF, 1'b1, 1'b0, NO_HIT},
        '{ROW_ITEM, '0, '0, REQ_DATA, 6'd63, 8'h41, 1'b0, 1'b0, NO_HIT},
        '{ROW_ITEM, '0, '0, REQ_DATA, 6'd63, 8'h41, 1'b1, 1'b1, '{1'b1, 48'h0}},
        '{ROW_REG, CFG_BASE_ADDRESS, ADDR_MAX, REQ_LOAD, '0, '0, 1'b0, 1'b0, NO_HIT},
        '{ROW_REG, CFG_PATTERN_LENGTH, 48'd0, REQ_LOAD, '0, '0, 1'b0, 1'b0, NO_HIT},
        '{ROW_REG, CFG_UNMAPPED, ADDR_MAX, REQ_LOAD, '0, '0, 1'b0, 1'b0, NO_HIT},
        '{ROW_ITEM, '0, '0, REQ_DATA, 6'd0,  8'h00, 1'b0, 1'b0, NO_HIT},
        '{ROW_ITEM, '0, '0, REQ_DATA, 6'd0,  8'hFF, 1'b1, 1'b1, '{1'b1, ADDR_MAX}},
        '{ROW_REG, CFG_WILDCARD_BYTE, 48'h41, REQ_LOAD, '0, '0, 1'b0, 1'b0, NO_HIT},
        '{ROW_REG, CFG_PATTERN_LENGTH, 48'd2, REQ_LOAD, '0, '0, 1'b0, 1'b0, NO_HIT},
        '{ROW_ITEM, '0, '0, REQ_LOAD, 6'd1,  8'h00, 1'b0, 1'b0, NO_HIT},
        '{ROW_ITEM, '0, '0, REQ_DATA, 6'd0,  8'h55, 1'b0, 1'b0, NO_HIT},
        '{ROW_ITEM, '0, '0, REQ_DATA, 6'd0,  8'h55, 1'b0, 1'b0, NO_HIT},
        '{ROW_ITEM, '0, '0, REQ_DATA, 6'd0,  8'h00, 1'b1, 1'b0, NO_HIT},
        '{ROW_REG, CFG_BASE_ADDRESS, 48'h0, REQ_LOAD, '0, '0, 1'b0, 1'b0, NO_HIT},
        '{ROW_ITEM, '0, '0, REQ_DATA, 6'd0,  8'h77, 1'b0, 1'b0, NO_HIT},
        '{ROW_ITEM, '0, '0, REQ_LOAD, 6'd1,  8'h77, 1'b0, 1'b0, NO_HIT},
        '{ROW_ITEM, '0, '0, REQ_DATA, 6'd0,  8'h77, 1'b0, 1'b0, NO_HIT},
        '{ROW_ITEM, '0, '0, REQ_DATA, 6'd0,  8'h12, 1'b1, 1'b0, NO_HIT},
        '{ROW_ITEM, '0, '0, REQ_DATA, 6'd0,  8'hFF, 1'b1, 1'b1, NO_HIT},
        '{ROW_REG, CFG_WILDCARD_BYTE, 48'hFF, REQ_LOAD, '0, '0, 1'b0, 1'b0, NO_HIT},
        '{ROW_ITEM, '0, '0, REQ_DATA, 6'd0,  8'h00, 1'b1, 1'b1, NO_HIT}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata;   // [5:0] pattern_index, [13:6] byte_value
    logic                  s_axis_tuser;   // [0] req_type
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;  // [0] found, [48:1] match_address

    // scanner mirror: pattern store, running match bits and region tracking
    logic [BYTE_W-1:0] pat_mirror [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] run_bits = '0;
    logic [POS_W-1:0]  scan_pos   = '0;
    logic              hit_seen   = 1'b0;
    logic [POS_W-1:0]  hit_offset = '0;
    logic [LEN_W-1:0]  len_reg    = 7'd1;
    logic [BYTE_W-1:0] wild_reg   = '0;
    logic [ADDR_W-1:0] base_reg   = '0;

    t_scan_report pending_reports [$];
    t_scan_report want;
    int           fail_count   = 0;
    int           items_sent   = 0;
    int           quiet_cycles = 0;
    bit           no_idle      = 1'b0;

    wildcard_byte_pattern_search dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Advance the mirror by one item; returns 1 when the item closes a region.
    function automatic bit scan_byte(input logic req, input logic [IDX_W-1:0] idx,
                                     input logic [BYTE_W-1:0] val, input logic last,
                                     output t_scan_report rep);
        int unsigned eff;
        logic [PATTERN_MAX-1:0] nxt;
        rep = NO_HIT;
        if (req == REQ_LOAD) begin
            pat_mirror[idx] = val;
            return 1'b0;
        end
        eff = (len_reg > PATTERN_MAX) ? PATTERN_MAX : len_reg;
        if (eff == 0) begin
            run_bits = '0;
            if (!hit_seen) begin
                hit_seen   = 1'b1;
                hit_offset = scan_pos;
            end
        end else begin
            nxt = '0;
            for (int k = 0; k < eff; k++) begin
                nxt[k] = (pat_mirror[k] == wild_reg || pat_mirror[k] == val) &&
                         ((k == 0) ? 1'b1 : run_bits[k-1]);
            end
            run_bits = nxt;
            if (run_bits[eff-1] && !hit_seen) begin
                hit_seen   = 1'b1;
                hit_offset = scan_pos - POS_W'(eff - 1);
            end
        end
        scan_pos = scan_pos + POS_W'(1);
        if (!last)
            return 1'b0;
        rep.found = hit_seen;
        rep.addr  = hit_seen ? base_reg + ADDR_W'(hit_offset) : '0;
        run_bits   = '0;
        scan_pos   = '0;
        hit_seen   = 1'b0;
        hit_offset = '0;
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic idle_sender();
        int g;
        g = no_idle ? 0 : pick_gap();
        if (g != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // Valid stays high after the handshake; idle_sender or settle drops it.
    task automatic send_item(input logic req, input logic [IDX_W-1:0] idx,
                             input logic [BYTE_W-1:0] val, input logic last,
                             input bit pinned, input t_scan_report pin);
        t_scan_report rep;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tlast  <= last;
        s_axis_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, val, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        if (scan_byte(req, idx, val, last, rep))
            pending_reports.push_back(pinned ? pin : rep);
        items_sent++;
        idle_sender();
    endtask

    // Config valid stays high; the caller drops it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] ridx,
                             input logic [CFG_DATA_W-1:0] rval);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= ridx;
        i_cfg_data  <= rval;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (ridx)
            CFG_PATTERN_LENGTH: len_reg  = rval[LEN_W-1:0];
            CFG_WILDCARD_BYTE:  wild_reg = rval[BYTE_W-1:0];
            CFG_BASE_ADDRESS:   base_reg = rval[ADDR_W-1:0];
            default: ;
        endcase
    endtask

    // Hold input until every report is back, then let the pipeline empty.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // result check and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_reports.size() == 0) begin
                    $error("unexpected report: found %0d match_address %h",
                           m_axis_tdata[0], m_axis_tdata[ADDR_W:1]);
                    fail_count++;
                end else begin
                    want = pending_reports.pop_front();
                    if (m_axis_tdata[0] !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, m_axis_tdata[0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[ADDR_W:1] !== want.addr) begin
                        $error("match_address: expected %h, got %h",
                               want.addr, m_axis_tdata[ADDR_W:1]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // receiver: random stalls, with stall-free stretches in some phases
    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : pick_gap();
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    initial begin
        t_dir_row          row;
        int                eff, rlen, p, nreg, rr, fill;
        bit                first_fill, noisy;
        logic [LEN_W-1:0]  len_pick;
        logic [BYTE_W-1:0] wild_pick, a0, a1, bval;
        logic [ADDR_W-1:0] base_pick;
        logic [BYTE_W-1:0] region_buf [REGION_MAX];

        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= REQ_LOAD;
        s_axis_tlast  <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            row = dir_tab[r];
            if (row.kind == ROW_REG) begin
                if (r == 0 || dir_tab[r-1].kind != ROW_REG)
                    settle();
                write_reg(row.reg_idx, row.reg_val);
                if (r == DIR_ROWS - 1 || dir_tab[r+1].kind != ROW_REG)
                    i_cfg_valid <= 1'b0;
            end else begin
                send_item(row.req, row.idx, row.val, row.last, row.pinned, row.pin);
            end
        end

        items_sent = 0;
        first_fill = 1'b1;
        while (items_sent < RANDOM_ITEMS) begin
            settle();
            no_idle = ($urandom_range(0, 3) == 0);

            rr = $urandom_range(0, 99);
            if (rr < 8)
                len_pick = 7'd0;
            else if (rr < 14)
                len_pick = 7'd127;
            else if (rr < 18)
                len_pick = LEN_W'($urandom_range(65, 126));
            else if (rr < 26)
                len_pick = 7'd64;
            else if (rr < 32)
                len_pick = 7'd63;
            else if (rr < 42)
                len_pick = 7'd1;
            else
                len_pick = LEN_W'($urandom_range(2, 12));
            eff = (len_pick > PATTERN_MAX) ? PATTERN_MAX : len_pick;

            rr = $urandom_range(0, 99);
            wild_pick = (rr < 15) ? 8'h00 : (rr < 30) ? 8'hFF : BYTE_W'($urandom);

            rr = $urandom_range(0, 99);
            if (rr < 15)
                base_pick = '0;
            else if (rr < 30)
                base_pick = ADDR_MAX;
            else if (rr < 45)
                base_pick = ADDR_MAX - ADDR_W'($urandom_range(0, 300));
            else
                base_pick = ADDR_W'({$urandom, $urandom});

            write_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(len_pick));
            write_reg(CFG_WILDCARD_BYTE, CFG_DATA_W'(wild_pick));
            write_reg(CFG_BASE_ADDRESS, base_pick);
            if ($urandom_range(0, 4) == 0)
                write_reg(CFG_UNMAPPED, CFG_DATA_W'({$urandom, $urandom}));
            i_cfg_valid <= 1'b0;

            // two close symbols so partial matches build up and break often
            a0 = BYTE_W'($urandom);
            a1 = a0 ^ (8'h01 << $urandom_range(0, 7));

            // the whole store is written once before any random data reads it
            fill = first_fill ? PATTERN_MAX : eff;
            first_fill = 1'b0;
            for (int k = 0; k < fill; k++) begin
                rr = $urandom_range(0, 99);
                bval = (rr < 20) ? wild_pick : (rr < 60) ? a0 : a1;
                send_item(REQ_LOAD, IDX_W'(k), bval, ($urandom_range(0, 19) == 0),
                          1'b0, NO_HIT);
            end

            nreg = $urandom_range(2, 8);
            for (int n = 0; n < nreg; n++) begin
                rlen = ($urandom_range(0, 99) < 5) ? $urandom_range(120, REGION_MAX)
                                                   : $urandom_range(1, eff + 20);
                noisy = ($urandom_range(0, 9) == 0);
                for (int i = 0; i < rlen; i++) begin
                    if (noisy || $urandom_range(0, 9) == 0)
                        region_buf[i] = BYTE_W'($urandom);
                    else
                        region_buf[i] = $urandom_range(0, 1) ? a0 : a1;
                end

                // plant the pattern, sometimes cut off by the start or the end of the region
                if (!noisy && eff > 0 && $urandom_range(0, 99) < 65) begin
                    if (rlen >= eff && $urandom_range(0, 5) != 0)
                        p = $urandom_range(0, rlen - eff);
                    else
                        p = rlen - int'($urandom_range(1, eff));
                    for (int j = 0; j < eff; j++) begin
                        if (p + j >= 0 && p + j < rlen)
                            region_buf[p + j] = (pat_mirror[j] == wild_pick) ?
                                                BYTE_W'($urandom) : pat_mirror[j];
                    end
                end

                for (int i = 0; i < rlen; i++) begin
                    if ($urandom_range(0, 29) == 0)
                        send_item(REQ_LOAD, IDX_W'($urandom), $urandom_range(0, 1) ? a0 : a1,
                                  1'($urandom_range(0, 1)), 1'b0, NO_HIT);
                    send_item(REQ_DATA, IDX_W'($urandom), region_buf[i], (i == rlen - 1),
                              1'b0, NO_HIT);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
